// ===== hdl/ordered_timer_queue_top_assert.svh =====
// assertion macros for the timer queue checker
// no dependencies
`ifndef ORDERED_TIMER_QUEUE_TOP_ASSERT_SVH
`define ORDERED_TIMER_QUEUE_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define OTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define OTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/otq_pkg.sv =====
// shared types and codes for the timer queue
// no dependencies
package otq_pkg;
    localparam int unsigned TimeW = 63;
    localparam int unsigned IdW = 32;

    localparam logic [1:0] CMD_SCHED = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_RUN = 2'd3;

    localparam logic [2:0] ST_SCHED = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_CANCEL = 3'd2;
    localparam logic [2:0] ST_FIRED = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCHED,
        S_CANCEL,
        S_CLOCK,
        S_PICK,
        S_EMIT,
        S_NONE,
        S_WAIT
    } otq_state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic do_sched;
        logic do_cancel;
        logic do_clock;
        logic emit_fire;
        logic emit_plain;
        logic [2:0] plain_status;
    } otq_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic single;
        logic [1:0] cmd;
        logic neg_advance;
        logic out_busy;
    } otq_stat_t;
endpackage

// ===== hdl/otq_datapath.sv =====
// timer table, virtual clock and sequential scan datapath
// depends on otq_pkg
module otq_datapath #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [1:0] cmd,
    input  logic signed [63:0] delay_ns,
    input  logic [31:0] cancel_id,
    input  logic signed [63:0] advance_ns,
    input  otq_pkg::otq_cmd_t ctl,
    output otq_pkg::otq_stat_t stat,
    output logic out_valid,
    input  logic out_ready,
    output logic [2:0] status,
    output logic [31:0] task_ident,
    output logic [62:0] due_time,
    output logic [62:0] clock_now,
    output logic last
);
    import otq_pkg::*;
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [TimeW-1:0] MaxT = '1;

    logic [1:0] cmd_reg;
    logic [63:0] arg_reg;
    logic [IdW-1:0] cid_reg;
    logic [TimeW-1:0] clock_reg;
    logic [IdW-1:0] nid_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [IdW-1:0] ident_mem [TABLE_DEPTH];
    logic [TimeW-1:0] due_mem [TABLE_DEPTH];
    logic [CW-1:0] idx_reg;
    logic found_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] best_reg;
    logic [TimeW-1:0] best_due_reg;
    logic [IdW-1:0] best_id_reg;
    logic [TimeW-1:0] limit_reg;
    logic [TimeW-1:0] maxdue_reg;
    logic rd_live_reg;
    logic rd_v_reg;
    logic [TimeW-1:0] rd_due_reg;
    logic [IdW-1:0] rd_id_reg;
    logic [IW-1:0] rd_idx_reg;
    logic ov_reg;
    logic [2:0] st_reg;
    logic [IdW-1:0] oid_reg;
    logic [TimeW-1:0] odue_reg;
    logic [TimeW-1:0] onow_reg;
    logic olast_reg;

    logic [IW-1:0] idx;
    logic [TimeW-1:0] arg_pos;
    logic [TimeW:0] sum;
    logic [TimeW-1:0] sat;
    logic [TimeW-1:0] cur_due;
    logic [IdW-1:0] cur_id;
    logic cur_v;
    logic better;
    logic [TimeW-1:0] new_due;

    assign idx = idx_reg[IW-1:0];
    assign cur_v = rd_v_reg;
    assign cur_due = rd_due_reg;
    assign cur_id = rd_id_reg;
    assign better = !found_reg || (cur_due < best_due_reg)
        || ((cur_due == best_due_reg) && (cur_id < best_id_reg));
    assign arg_pos = arg_reg[63] ? '0 : arg_reg[TimeW-1:0];
    assign sum = {1'b0, clock_reg} + {1'b0, arg_pos};
    assign sat = sum[TimeW] ? MaxT : sum[TimeW-1:0];
    assign new_due = sat;

    assign stat.scan_done = (idx_reg == CW'(TABLE_DEPTH)) && !rd_live_reg;
    assign stat.found = found_reg;
    assign stat.single = (cnt_reg == CW'(1));
    assign stat.cmd = cmd_reg;
    assign stat.neg_advance = arg_reg[63];
    assign stat.out_busy = ov_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            arg_reg <= (cmd == CMD_ADVANCE) ? advance_ns : delay_ns;
            cid_reg <= cancel_id;
        end
        if (ctl.do_sched)
        begin
            ident_mem[best_reg] <= nid_reg;
            due_mem[best_reg] <= new_due;
        end
        if (ctl.scan_start)
        begin
            idx_reg <= '0;
            rd_live_reg <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg <= '0;
            best_reg <= '0;
            best_due_reg <= '0;
            best_id_reg <= '0;
            maxdue_reg <= clock_reg;
            limit_reg <= (cmd_reg == CMD_RUN) ? MaxT : (ctl.do_clock ? sat : clock_reg);
        end
        else if (ctl.scan_step)
        begin
            if (idx_reg != CW'(TABLE_DEPTH))
            begin
                idx_reg <= idx_reg + 1'b1;
                rd_live_reg <= 1'b1;
            end
            else
                rd_live_reg <= 1'b0;
            rd_v_reg <= valid_reg[idx];
            rd_due_reg <= due_mem[idx];
            rd_id_reg <= ident_mem[idx];
            rd_idx_reg <= idx;
            if (rd_live_reg)
            begin
                case (cmd_reg)
                    CMD_SCHED:
                    begin
                        if (!cur_v && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            best_reg <= rd_idx_reg;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (cur_v && cur_id == cid_reg && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            best_reg <= rd_idx_reg;
                        end
                    end
                    default:
                    begin
                        if (cur_v && cur_due > maxdue_reg)
                            maxdue_reg <= cur_due;
                        if (cur_v && cur_due <= limit_reg)
                            cnt_reg <= cnt_reg + 1'b1;
                        if (cur_v && cur_due <= limit_reg && better)
                        begin
                            found_reg <= 1'b1;
                            best_reg <= rd_idx_reg;
                            best_due_reg <= cur_due;
                            best_id_reg <= cur_id;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
            nid_reg <= 32'd1;
            valid_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (ctl.do_sched)
            begin
                valid_reg[best_reg] <= 1'b1;
                nid_reg <= nid_reg + 1'b1;
            end
            if (ctl.do_cancel)
                valid_reg[best_reg] <= 1'b0;
            if (ctl.do_clock)
                clock_reg <= (cmd_reg == CMD_RUN) ? maxdue_reg : sat;
            if (ctl.emit_fire)
                valid_reg[best_reg] <= 1'b0;
            if (ctl.emit_fire || ctl.emit_plain)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_fire)
        begin
            st_reg <= ST_FIRED;
            oid_reg <= best_id_reg;
            odue_reg <= best_due_reg;
            onow_reg <= (cmd_reg == CMD_RUN) ? maxdue_reg : clock_reg;
            olast_reg <= stat.single;
        end
        else if (ctl.emit_plain)
        begin
            st_reg <= ctl.plain_status;
            oid_reg <= (ctl.plain_status == ST_SCHED) ? nid_reg
                : (ctl.plain_status == ST_CANCEL) ? cid_reg : '0;
            odue_reg <= (ctl.plain_status == ST_SCHED) ? new_due : '0;
            onow_reg <= clock_reg;
            olast_reg <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign task_ident = oid_reg;
    assign due_time = odue_reg;
    assign clock_now = onow_reg;
    assign last = olast_reg;
endmodule

// ===== hdl/otq_ctrl.sv =====
// controller state machine for the timer queue
// depends on otq_pkg
module otq_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  otq_pkg::otq_stat_t stat,
    output otq_pkg::otq_cmd_t ctl
);
    import otq_pkg::*;
    otq_state_t state_reg, state_next;
    logic fire_mode;

    assign fire_mode = (stat.cmd == CMD_ADVANCE) || (stat.cmd == CMD_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CLOCK;
            S_CLOCK:
                if (stat.cmd == CMD_ADVANCE && stat.neg_advance)
                    state_next = S_NONE;
                else
                    state_next = S_SCAN;
            S_SCAN:
                if (stat.scan_done)
                begin
                    if (stat.cmd == CMD_SCHED)
                        state_next = S_SCHED;
                    else if (stat.cmd == CMD_CANCEL)
                        state_next = S_CANCEL;
                    else
                        state_next = S_PICK;
                end
            S_SCHED:
                if (!stat.out_busy)
                    state_next = S_WAIT;
            S_CANCEL:
                if (!stat.out_busy)
                    state_next = S_WAIT;
            S_PICK:
                if (!stat.found)
                    state_next = S_NONE;
                else if (!stat.out_busy)
                    state_next = stat.single ? S_WAIT : S_EMIT;
            S_EMIT:
                state_next = S_SCAN;
            S_NONE:
                if (!stat.out_busy)
                    state_next = S_WAIT;
            S_WAIT:
                if (!stat.out_busy)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_CLOCK:
            begin
                ctl.do_clock = (stat.cmd == CMD_ADVANCE) && !stat.neg_advance;
                ctl.scan_start = 1'b1;
            end
            S_SCAN:
                ctl.scan_step = !stat.scan_done;
            S_SCHED:
                if (!stat.out_busy)
                begin
                    ctl.do_sched = stat.found;
                    ctl.emit_plain = 1'b1;
                    ctl.plain_status = stat.found ? ST_SCHED : ST_FULL;
                end
            S_CANCEL:
                if (!stat.out_busy)
                begin
                    ctl.do_cancel = stat.found;
                    ctl.emit_plain = 1'b1;
                    ctl.plain_status = ST_CANCEL;
                end
            S_PICK:
            begin
                ctl.emit_fire = stat.found && !stat.out_busy;
                ctl.do_clock = (stat.cmd == CMD_RUN) && stat.found && !stat.out_busy;
            end
            S_EMIT:
                ctl.scan_start = 1'b1;
            S_NONE:
                if (!stat.out_busy)
                begin
                    ctl.do_clock = fire_mode && (stat.cmd == CMD_RUN);
                    ctl.emit_plain = 1'b1;
                    ctl.plain_status = ST_NONE;
                end
            S_WAIT:
                ctl = '0;
            default:
                ctl = '0;
        endcase
    end
endmodule

// ===== hdl/ordered_timer_queue_top.sv =====
// top level of the ordered timer queue
// depends on otq_pkg, otq_ctrl, otq_datapath
//
// channel  | valid     | ready     | payload
// input    | in_valid  | in_ready  | cmd, delay_ns, cancel_id, advance_ns
// output   | out_valid | out_ready | status, task_ident, due_time, clock_now, last
//
// a table scan reads one slot per cycle through registered reads
// schedule and cancel: the result follows one table scan after the input transfer
// advance and run: one scan per fired task, the last fired task carries last;
//   a negative advance answers without scanning the table
// reset clears the clock and all valid bits and sets the id counter to 1 at once
// in_ready is high only when idle; a stalled output holds the controller
module ordered_timer_queue_top #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] cmd,
    input  logic signed [63:0] delay_ns,
    input  logic [31:0] cancel_id,
    input  logic signed [63:0] advance_ns,
    output logic out_valid,
    input  logic out_ready,
    output logic [2:0] status,
    output logic [31:0] task_ident,
    output logic [62:0] due_time,
    output logic [62:0] clock_now,
    output logic last
);
    import otq_pkg::*;
    otq_cmd_t ctl;
    otq_stat_t stat;
    logic [2:0] st_raw;
    logic [31:0] id_raw;
    logic [62:0] due_raw;
    logic [62:0] now_raw;
    logic last_raw;
    logic ov_raw;

    otq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(stat), .ctl(ctl)
    );

    otq_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .delay_ns(delay_ns),
        .cancel_id(cancel_id), .advance_ns(advance_ns), .ctl(ctl), .stat(stat),
        .out_valid(ov_raw), .out_ready(out_ready), .status(st_raw),
        .task_ident(id_raw), .due_time(due_raw), .clock_now(now_raw),
        .last(last_raw)
    );

    assign out_valid = ov_raw;
    assign status = st_raw;
    assign task_ident = id_raw;
    assign due_time = due_raw;
    assign clock_now = now_raw;
    assign last = last_raw;
endmodule

// ===== hdl/otq_checker.sv =====
// port-level checker for the timer queue, bound to the top level
// depends on otq_pkg and ordered_timer_queue_top_assert.svh
`include "ordered_timer_queue_top_assert.svh"
module otq_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] status,
    input logic last
);
    import otq_pkg::*;
    `OTQ_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, status <= ST_NONE, "bad status")
    `OTQ_ASSERT_IMP(a_fired_not_final_plain, clk, rst_n, out_valid && status != ST_FIRED, last, "plain result must be final")
    `OTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status), "output dropped")
    `OTQ_ASSERT_IMP(a_busy_no_ready, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
endmodule

bind ordered_timer_queue_top otq_checker u_otq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .last(last)
);

// ===== verif/ordered_timer_queue_top_tb.sv =====
// testbench for the ordered timer queue: directed table, hold-off, then random commands,
// every result checked against an in-bench timer table predictor
// depends on otq_pkg and ordered_timer_queue_top
module ordered_timer_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import otq_pkg::*;

    localparam int Depth = 16;
    localparam logic [62:0] Max63 = {63{1'b1}};
    localparam int Limit = 2000000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [63:0] delay;
        logic [31:0] cid;
        logic [63:0] adv;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [31:0] ident;
        logic [62:0] due;
        logic [62:0] now;
        logic last;
    } timer_result_t;

    typedef struct {
        cmd_item_t item;
        bit known;
        timer_result_t res;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = '0;
    logic signed [63:0] delay_ns = '0;
    logic [31:0] cancel_id = '0;
    logic signed [63:0] advance_ns = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [31:0] task_ident;
    logic [62:0] due_time;
    logic [62:0] clock_now;
    logic last;

    ordered_timer_queue_top #(.TABLE_DEPTH(Depth)) DUT (.*);

    always #10 clk = ~clk;

    // predictor state
    logic [62:0] model_now;
    logic [31:0] model_next_id;
    bit slot_busy [Depth];
    logic [31:0] slot_id [Depth];
    logic [62:0] slot_due [Depth];

    timer_result_t pending_results[$];
    int failures = 0;
    int cycles = 0;
    bit hold_off = 1'b0;
    table_row_t rows[$];

    function automatic logic [62:0] sat_sum(logic [62:0] a, logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? Max63 : s[62:0];
    endfunction

    function automatic timer_result_t mk(logic [2:0] st, logic [31:0] id,
                                         logic [62:0] due, logic lst);
        timer_result_t r;
        r.status = st;
        r.ident = id;
        r.due = due;
        r.now = model_now;
        r.last = lst;
        return r;
    endfunction

    function automatic void add_result(timer_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic fire_due(logic [62:0] lim);
        int best;
        int n;
        n = 0;
        forever
        begin
            best = -1;
            for (int i = 0; i < Depth; i++)
            begin
                if (slot_busy[i] && slot_due[i] <= lim &&
                    (best < 0 || slot_due[i] < slot_due[best] ||
                     (slot_due[i] == slot_due[best] && slot_id[i] < slot_id[best])))
                    best = i;
            end
            if (best < 0)
                break;
            slot_busy[best] = 1'b0;
            add_result(mk(ST_FIRED, slot_id[best], slot_due[best], 1'b0));
            n++;
        end
        if (n == 0)
            add_result(mk(ST_NONE, '0, '0, 1'b1));
        else
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    task automatic predict_timers(cmd_item_t it);
        int slot;
        logic [62:0] due;
        slot = -1;
        case (it.cmd)
            CMD_SCHED:
            begin
                for (int i = 0; i < Depth; i++)
                    if (!slot_busy[i] && slot < 0)
                        slot = i;
                if (slot < 0)
                    add_result(mk(ST_FULL, '0, '0, 1'b1));
                else
                begin
                    due = sat_sum(model_now, it.delay[63] ? 63'd0 : it.delay[62:0]);
                    slot_busy[slot] = 1'b1;
                    slot_id[slot] = model_next_id;
                    slot_due[slot] = due;
                    add_result(mk(ST_SCHED, model_next_id, due, 1'b1));
                    model_next_id = model_next_id + 32'd1;
                end
            end
            CMD_CANCEL:
            begin
                for (int i = 0; i < Depth; i++)
                    if (slot < 0 && slot_busy[i] && slot_id[i] == it.cid)
                        slot = i;
                if (slot >= 0)
                    slot_busy[slot] = 1'b0;
                add_result(mk(ST_CANCEL, it.cid, '0, 1'b1));
            end
            CMD_ADVANCE:
            begin
                if (it.adv[63])
                    add_result(mk(ST_NONE, '0, '0, 1'b1));
                else
                begin
                    model_now = sat_sum(model_now, it.adv[62:0]);
                    fire_due(model_now);
                end
            end
            default:
            begin
                for (int i = 0; i < Depth; i++)
                    if (slot_busy[i] && slot_due[i] > model_now)
                        model_now = slot_due[i];
                fire_due(Max63);
            end
        endcase
    endtask

    function automatic cmd_item_t item_of(logic [1:0] c, logic [63:0] d,
                                          logic [31:0] id, logic [63:0] a);
        cmd_item_t it;
        it.cmd = c;
        it.delay = d;
        it.cid = id;
        it.adv = a;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = {32'hFFFF_FFFF, $urandom};
            2: v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 50));
            default: v = 64'($urandom_range(0, 400));
        endcase
        return v;
    endfunction

    task automatic send_item(cmd_item_t it);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= it.cmd;
        delay_ns <= it.delay;
        cancel_id <= it.cid;
        advance_ns <= it.adv;
        do
            @(posedge clk);
        while (!in_ready);
        predict_timers(it);
    endtask

    task automatic add_row(cmd_item_t it, bit known, timer_result_t r);
        table_row_t row;
        row.item = it;
        row.known = known;
        row.res = r;
        rows.insert(rows.size(), row);
    endtask

    // output side
    initial
    begin
        timer_result_t exp_r;
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: actual %p", $realtime,
                             {status, task_ident, due_time, clock_now, last});
                    failures++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if ({status, task_ident, due_time, clock_now, last} !== exp_r)
                    begin
                        $display("%0t mismatch: expected st=%0d id=%0d due=%0d now=%0d last=%0d",
                                 $realtime, exp_r.status, exp_r.ident, exp_r.due,
                                 exp_r.now, exp_r.last);
                        $display("%0t           actual st=%0d id=%0d due=%0d now=%0d last=%0d",
                                 $realtime, status, task_ident, due_time, clock_now, last);
                        failures++;
                    end
                end
            end
            if (hold_off)
                out_ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                stall = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : 1;
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // known results from the directed table, checked against the predictor's view
    task automatic check_typed(timer_result_t want);
        timer_result_t got;
        got = pending_results[pending_results.size() - 1];
        if (got !== want)
        begin
            $display("%0t table mismatch: expected %p actual %p", $realtime, want, got);
            failures++;
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > Limit)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_item_t it;
        int k;
        for (int i = 0; i < Depth; i++)
            slot_busy[i] = 1'b0;
        model_now = '0;
        model_next_id = 32'd1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(item_of(CMD_RUN, '0, '0, '0), 1, '{ST_NONE, 0, 0, 0, 1});
        add_row(item_of(CMD_ADVANCE, '0, '0, 64'h8000_0000_0000_0000), 1,
                '{ST_NONE, 0, 0, 0, 1});
        add_row(item_of(CMD_CANCEL, '0, 32'hFFFF_FFFF, '0), 1,
                '{ST_CANCEL, 32'hFFFF_FFFF, 0, 0, 1});
        add_row(item_of(CMD_SCHED, 64'h8000_0000_0000_0000, '0, '0), 1,
                '{ST_SCHED, 1, 0, 0, 1});
        add_row(item_of(CMD_SCHED, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0), 1,
                '{ST_SCHED, 2, Max63, 0, 1});
        add_row(item_of(CMD_SCHED, 64'd5, '0, '0), 1, '{ST_SCHED, 3, 5, 0, 1});
        add_row(item_of(CMD_SCHED, 64'd5, '0, '0), 0, '0);
        add_row(item_of(CMD_CANCEL, '0, 32'd3, '0), 0, '0);
        add_row(item_of(CMD_ADVANCE, '0, '0, 64'd10), 0, '0);
        for (int i = 0; i < Depth; i++)
            add_row(item_of(CMD_SCHED, 64'(i % 3), '0, '0), 0, '0);
        add_row(item_of(CMD_ADVANCE, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF), 0, '0);
        add_row(item_of(CMD_SCHED, 64'd1, '0, '0), 0, '0);
        add_row(item_of(CMD_RUN, '0, '0, '0), 0, '0);

        foreach (rows[i])
        begin
            send_item(rows[i].item);
            if (rows[i].known)
                check_typed(rows[i].res);
        end
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);

        // id wrap: clock is saturated, so only the counter matters; drive ids far
        // via many schedules is too slow, so rely on random cancels of high ids

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int j = 0; j < 20; j++)
                    send_item(item_of(2'($urandom_range(0, 1)), 64'($urandom_range(0, 9)),
                                      32'($urandom_range(0, 40)), '0));
                in_valid <= 1'b0;
            end
        join

        // random part: bursts of schedules, cancels and clock moves
        for (int n = 0; n < 122; n++)
        begin
            k = $urandom_range(0, 19);
            if (k < 9)
                it = item_of(CMD_SCHED, rand64(), '0, '0);
            else if (k < 13)
                it = item_of(CMD_CANCEL, '0,
                             ($urandom_range(0, 4) == 0) ? $urandom
                                 : model_next_id - 32'($urandom_range(1, 20)), '0);
            else if (k < 18)
                it = item_of(CMD_ADVANCE, '0, '0, rand64());
            else
                it = item_of(CMD_RUN, rand64(), $urandom, rand64());
            send_item(it);
        end
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
